// ===== rtl/nps3_pkg.sv =====
// ----------------------------------------------------------------------------
// nps3_pkg: shared types and constants for the 3D nearest point search
// Op codes, default sizes and the sequencer state type.
// ----------------------------------------------------------------------------
package nps3_pkg;

   localparam int DEF_MAX_POINTS = 16384;
   localparam int DEF_COORD_BITS = 18;

   localparam int OP_W = 2;

   localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
   localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FINISH
   } state_type;

endpackage

// ===== rtl/nps3_point_mem.sv =====
// ----------------------------------------------------------------------------
// nps3_point_mem: point store
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module nps3_point_mem
   import nps3_pkg::*;
#(
   parameter int DEPTH = DEF_MAX_POINTS,
   parameter int WIDTH = 3 * DEF_COORD_BITS,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/nps3_dist_unit.sv =====
// ----------------------------------------------------------------------------
// nps3_dist_unit: shared squared distance unit
// Forms three coordinate differences and squares them into registers, then
// sums the registered squares. Accepts one point per cycle.
// ----------------------------------------------------------------------------
module nps3_dist_unit
   import nps3_pkg::*;
#(
   parameter int COORD_BITS = DEF_COORD_BITS,
   parameter int IDX_W      = 14,
   parameter int DIST_W     = 2 * COORD_BITS + 2
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic [IDX_W-1:0]        in_index,
   input  logic [COORD_BITS-1:0]   query_x,
   input  logic [COORD_BITS-1:0]   query_y,
   input  logic [COORD_BITS-1:0]   query_z,
   input  logic [3*COORD_BITS-1:0] point,
   output logic                    out_valid,
   output logic [IDX_W-1:0]        out_index,
   output logic [DIST_W-1:0]       out_dist
);

   localparam int C    = COORD_BITS;
   localparam int DW   = C + 1;
   localparam int SQ_W = 2 * C + 1;

   logic signed [DW-1:0]   dx, dy, dz;
   logic signed [2*DW-1:0] px2, py2, pz2;

   logic [SQ_W-1:0]  sq_x_ff, sq_y_ff, sq_z_ff;
   logic             valid_ff;
   logic [IDX_W-1:0] index_ff;

   always_comb begin
      dx  = $signed({query_x[C-1], query_x}) - $signed({point[3*C-1], point[3*C-1:2*C]});
      dy  = $signed({query_y[C-1], query_y}) - $signed({point[2*C-1], point[2*C-1:C]});
      dz  = $signed({query_z[C-1], query_z}) - $signed({point[C-1], point[C-1:0]});
      px2 = dx * dx;
      py2 = dy * dy;
      pz2 = dz * dz;
   end

   always_ff @(posedge clock) begin
      sq_x_ff  <= px2[SQ_W-1:0];
      sq_y_ff  <= py2[SQ_W-1:0];
      sq_z_ff  <= pz2[SQ_W-1:0];
      index_ff <= in_index;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   assign out_valid = valid_ff;
   assign out_index = index_ff;
   assign out_dist  = DIST_W'(sq_x_ff) + DIST_W'(sq_y_ff) + DIST_W'(sq_z_ff);

endmodule

// ===== rtl/nearest_point_search_3d_unit.sv =====
// ----------------------------------------------------------------------------
// nearest_point_search_3d_unit: brute-force 3D nearest point search
// Load and clear beats complete while idle. A query walks all N stored points
// to its result (an empty store skips the walk): the distance unit sees one
// point per cycle, paced by the single read port of the point store.
// Reset empties the store (count to 0); stored points themselves are not reset.
// ----------------------------------------------------------------------------
module nearest_point_search_3d_unit
   import nps3_pkg::*;
#(
   parameter int MAX_POINTS = DEF_MAX_POINTS,
   parameter int COORD_BITS = DEF_COORD_BITS,
   parameter int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
   parameter int DIST_W     = 2 * COORD_BITS + 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [OP_W-1:0]       req_op,
   input  logic [COORD_BITS-1:0] req_x,
   input  logic [COORD_BITS-1:0] req_y,
   input  logic [COORD_BITS-1:0] req_z,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [IDX_W-1:0]      rsp_nearest_index,
   output logic [DIST_W-1:0]     rsp_min_distance,
   output logic                  rsp_store_empty
);

   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int PT_W  = 3 * COORD_BITS;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);

   // sequencer and store bookkeeping
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] addr_ff, addr_in;

   // query point, held for the whole walk
   logic [COORD_BITS-1:0] qx_ff, qy_ff, qz_ff;
   logic                  q_load;

   // running best
   logic              best_have_ff, best_have_in;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in;
   logic [DIST_W-1:0] best_dist_ff, best_dist_in;
   logic              empty_ff, empty_in;

   // read stage tag, lines up with registered store data
   logic             rd_valid_ff;
   logic [IDX_W-1:0] rd_index_ff;
   logic             issuing;

   logic              wr_en;
   logic [PT_W-1:0]   rd_point;
   logic              d_valid;
   logic [IDX_W-1:0]  d_index;
   logic [DIST_W-1:0] d_dist;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_load;
   logic [IDX_W-1:0]  rsp_idx_ff;
   logic [DIST_W-1:0] rsp_dist_ff;
   logic              rsp_empty_ff;

   // ---------------------------------------------------------------------
   // Point store: loads write at the current count, the walk reads by addr.
   // ---------------------------------------------------------------------
   nps3_point_mem #(
      .DEPTH (MAX_POINTS),
      .WIDTH (PT_W),
      .AW    (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data ({req_x, req_y, req_z}),
      .rd_addr (addr_ff[IDX_W-1:0]),
      .rd_data (rd_point)
   );

   // ---------------------------------------------------------------------
   // Distance unit: squares registered, sum presented to the compare below.
   // ---------------------------------------------------------------------
   nps3_dist_unit #(
      .COORD_BITS (COORD_BITS),
      .IDX_W      (IDX_W),
      .DIST_W     (DIST_W)
   ) u_dist (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rd_valid_ff),
      .in_index  (rd_index_ff),
      .query_x   (qx_ff),
      .query_y   (qy_ff),
      .query_z   (qz_ff),
      .point     (rd_point),
      .out_valid (d_valid),
      .out_index (d_index),
      .out_dist  (d_dist)
   );

   // Keep issuing addresses until every loaded point has gone out.
   assign issuing = (state_ff == ST_WALK) && (addr_ff < count_ff);

   // ---------------------------------------------------------------------
   // Sequencer: next state, store updates, best tracking, result handoff.
   // ---------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      addr_in      = addr_ff;
      best_have_in = best_have_ff;
      best_idx_in  = best_idx_ff;
      best_dist_in = best_dist_ff;
      empty_in     = empty_ff;
      req_ready    = 1'b0;
      wr_en        = 1'b0;
      q_load       = 1'b0;
      rsp_load     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_op)
                  OP_LOAD: begin
                     // drop loads once the store is full
                     if (count_ff != MAX_CNT) begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CNT_W'(1'b1);
                     end
                  end
                  OP_QUERY: begin
                     q_load       = 1'b1;
                     addr_in      = '0;
                     best_have_in = 1'b0;
                     best_idx_in  = '0;
                     best_dist_in = '0;
                     empty_in     = (count_ff == '0);
                     state_in     = (count_ff == '0) ? ST_FINISH : ST_WALK;
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WALK: begin
            if (issuing) begin
               addr_in = addr_ff + CNT_W'(1'b1);
            end
            // strictly smaller only: ties keep the lower index
            if (d_valid && (!best_have_ff || (d_dist < best_dist_ff))) begin
               best_have_in = 1'b1;
               best_idx_in  = d_index;
               best_dist_in = d_dist;
            end
            if (!issuing && !rd_valid_ff && !d_valid) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         addr_ff      <= '0;
         best_have_ff <= 1'b0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         addr_ff      <= addr_in;
         best_have_ff <= best_have_in;
         rd_valid_ff  <= issuing;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_index_ff  <= addr_ff[IDX_W-1:0];
      best_idx_ff  <= best_idx_in;
      best_dist_ff <= best_dist_in;
      empty_ff     <= empty_in;
      if (q_load) begin
         qx_ff <= req_x;
         qy_ff <= req_y;
         qz_ff <= req_z;
      end
      if (rsp_load) begin
         rsp_idx_ff   <= best_idx_ff;
         rsp_dist_ff  <= best_dist_ff;
         rsp_empty_ff <= empty_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_nearest_index = rsp_idx_ff;
   assign rsp_min_distance  = rsp_dist_ff;
   assign rsp_store_empty   = rsp_empty_ff;

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CNT)
      else $error("point count exceeds store capacity");

   a_dist_in_walk: assert property (@(posedge clock) disable iff (reset)
      d_valid |-> state_ff == ST_WALK)
      else $error("distance beat outside of a walk");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FINISH)
      else $error("result raised without finishing a query");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_empty_ff) |-> (rsp_idx_ff == '0 && rsp_dist_ff == '0))
      else $error("empty store result carries nonzero index or distance");

endmodule
